FILE: hdl/afr_pkg.sv
package afr_pkg;

   localparam int MAX_BODY_DEFAULT = 255;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_NO_START = 3'd1;
   localparam logic [2:0] ERR_STAR     = 3'd2;
   localparam logic [2:0] ERR_CRC      = 3'd3;
   localparam logic [2:0] ERR_COMMAS   = 3'd4;
   localparam logic [2:0] ERR_LONG     = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_line;
   } req_item_type;

   typedef struct packed {
      logic        frame_ok;
      logic [2:0]  error_code;
      logic [7:0]  node_id;
      logic [15:0] seq_number;
      logic [7:0]  sep_offset_1;
      logic [7:0]  sep_offset_2;
      logic [7:0]  sep_offset_3;
      logic [7:0]  sep_offset_4;
      logic [7:0]  body_length;
      logic [15:0] computed_crc;
   } rsp_item_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: hdl/afr_req_if.sv
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_line;

   modport source (output valid, output data_byte, output end_of_line, input ready);
   modport sink (input valid, input data_byte, input end_of_line, output ready);
endinterface

FILE: hdl/afr_rsp_if.sv
interface afr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [2:0]  error_code;
   logic [7:0]  node_id;
   logic [15:0] seq_number;
   logic [7:0]  sep_offset_1;
   logic [7:0]  sep_offset_2;
   logic [7:0]  sep_offset_3;
   logic [7:0]  sep_offset_4;
   logic [7:0]  body_length;
   logic [15:0] computed_crc;

   modport source (output valid, output frame_ok, output error_code, output node_id,
                   output seq_number, output sep_offset_1, output sep_offset_2,
                   output sep_offset_3, output sep_offset_4, output body_length,
                   output computed_crc, input ready);
   modport sink (input valid, input frame_ok, input error_code, input node_id,
                 input seq_number, input sep_offset_1, input sep_offset_2,
                 input sep_offset_3, input sep_offset_4, input body_length,
                 input computed_crc, output ready);
endinterface

FILE: hdl/ascii_frame_receiver_core.sv
// ASCII frame receiver: checks "@body*CRC" lines with a CRC-16/MODBUS trailer.
// req_chan carries one raw byte per request with end_of_line on the line's last
// byte. rsp_chan carries one verdict per line: frame_ok, error_code, node id,
// sequence number, first four comma offsets, body length and computed CRC.
// Bytes that are not the last of a line produce no response.
// Timing: a request lands in an input register, the parser updates its state
// from that register, and on the last byte writes the verdict into the
// response register. One byte is taken every cycle unless a last byte is
// held (see Stalls); the byte-wide CRC step and the field parsers sit in the
// single stage between the registers.
// Stalls: while a response waits, body bytes of the next line keep flowing;
// only a last byte held in the input register waits for the response register
// to free up, and req_chan.ready drops for that time.
// Reset (synchronous, active high) empties both registers and returns the
// parser to waiting for the start character; no clearing pass is needed.
module ascii_frame_receiver_core #(
   parameter int MAX_BODY = afr_pkg::MAX_BODY_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   afr_req_if.sink   req_chan,
   afr_rsp_if.source rsp_chan
);

   logic                  in_valid_ff, in_valid_in;
   afr_pkg::req_item_type in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   afr_pkg::rsp_item_type rsp_item_ff;
   afr_pkg::rsp_item_type result;
   logic                  advance;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!in_item_ff.end_of_line || out_free);

   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_chan.valid || (in_valid_ff && !advance);
   assign rsp_valid_in   = (rsp_valid_ff && !rsp_chan.ready) ||
                           (advance && in_item_ff.end_of_line);

   afr_parser #(
      .MAX_BODY(MAX_BODY)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.data_byte   <= req_chan.data_byte;
         in_item_ff.end_of_line <= req_chan.end_of_line;
      end
      if (advance && in_item_ff.end_of_line) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_ok     = rsp_item_ff.frame_ok;
   assign rsp_chan.error_code   = rsp_item_ff.error_code;
   assign rsp_chan.node_id      = rsp_item_ff.node_id;
   assign rsp_chan.seq_number   = rsp_item_ff.seq_number;
   assign rsp_chan.sep_offset_1 = rsp_item_ff.sep_offset_1;
   assign rsp_chan.sep_offset_2 = rsp_item_ff.sep_offset_2;
   assign rsp_chan.sep_offset_3 = rsp_item_ff.sep_offset_3;
   assign rsp_chan.sep_offset_4 = rsp_item_ff.sep_offset_4;
   assign rsp_chan.body_length  = rsp_item_ff.body_length;
   assign rsp_chan.computed_crc = rsp_item_ff.computed_crc;

   // body bytes never wait on the response side
   a_body_flows: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_item_ff.end_of_line |-> advance)
      else $error("body byte stalled");

   a_verdict_lands: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.end_of_line |=> rsp_valid_ff)
      else $error("verdict lost");

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.frame_ok == (rsp_item_ff.error_code == afr_pkg::ERR_OK)))
      else $error("frame_ok disagrees with error_code");

   a_fields_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.frame_ok |->
         (rsp_item_ff.node_id == 8'd0 && rsp_item_ff.seq_number == 16'd0))
      else $error("fields leak on a rejected frame");

   a_no_body_on_early_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.error_code == afr_pkg::ERR_NO_START ||
                       rsp_item_ff.error_code == afr_pkg::ERR_STAR) |->
         (rsp_item_ff.body_length == 8'd0 && rsp_item_ff.computed_crc == 16'd0))
      else $error("body snapshot shown without a valid star");

endmodule

FILE: hdl/afr_parser.sv
module afr_parser #(
   parameter int MAX_BODY = afr_pkg::MAX_BODY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  afr_pkg::req_item_type item,
   output afr_pkg::rsp_item_type result
);

   localparam logic [1:0] PH_WAIT   = 2'd0;
   localparam logic [1:0] PH_BODY   = 2'd1;
   localparam logic [1:0] PH_REJECT = 2'd2;

   localparam logic [1:0] HEX_LEAD   = 2'd0;
   localparam logic [1:0] HEX_ZERO   = 2'd1;
   localparam logic [1:0] HEX_DIGITS = 2'd2;
   localparam logic [1:0] HEX_DONE   = 2'd3;

   localparam logic [1:0] NUM_LEAD = 2'd0;
   localparam logic [1:0] NUM_POS  = 2'd1;
   localparam logic [1:0] NUM_NEG  = 2'd2;
   localparam logic [1:0] NUM_IDLE = 2'd3;

   localparam logic [8:0] MAX_BODY_CNT = 9'(MAX_BODY);

   logic [1:0]      phase_ff, phase_in;
   logic [15:0]     crc_ff, crc_in;
   logic [15:0]     crc_star_ff, crc_star_in;
   logic [8:0]      body_cnt_ff, body_cnt_in;
   logic [8:0]      len_star_ff, len_star_in;
   logic            star_ff, star_in;
   logic            nonspace_ff, nonspace_in;
   logic [15:0]     hex_val_ff, hex_val_in;
   logic [1:0]      hex_ph_ff, hex_ph_in;
   logic [2:0]      comma_cnt_ff, comma_cnt_in;
   logic [2:0]      commas_star_ff, commas_star_in;
   logic [3:0][7:0] offs_ff, offs_in;
   logic [7:0]      node_ff, node_in;
   logic [15:0]     seq_ff, seq_in;
   logic [1:0]      num_ph_ff, num_ph_in;
   logic            too_long_ff, too_long_in;

   always_comb begin
      logic [7:0]  b;
      logic [4:0]  hx;
      logic        dec;
      logic [3:0]  dval;
      logic        num_go;
      logic [7:0]  node_x10;
      logic [15:0] seq_x10;
      logic [2:0]  err;

      phase_in       = phase_ff;
      crc_in         = crc_ff;
      crc_star_in    = crc_star_ff;
      body_cnt_in    = body_cnt_ff;
      len_star_in    = len_star_ff;
      star_in        = star_ff;
      nonspace_in    = nonspace_ff;
      hex_val_in     = hex_val_ff;
      hex_ph_in      = hex_ph_ff;
      comma_cnt_in   = comma_cnt_ff;
      commas_star_in = commas_star_ff;
      offs_in        = offs_ff;
      node_in        = node_ff;
      seq_in         = seq_ff;
      num_ph_in      = num_ph_ff;
      too_long_in    = too_long_ff;

      b      = item.data_byte;
      hx     = afr_pkg::hex_digit(b);
      dec    = (b >= afr_pkg::CH_ZERO) && (b <= afr_pkg::CH_NINE);
      dval   = b[3:0];
      num_go = 1'b0;
      node_x10 = {node_ff[4:0], 3'b000} + {node_ff[6:0], 1'b0};
      seq_x10  = {seq_ff[12:0], 3'b000} + {seq_ff[14:0], 1'b0};

      unique case (phase_ff)
         PH_WAIT: begin
            if (!afr_pkg::is_ws(b)) begin
               if (b == afr_pkg::CH_AT) begin
                  phase_in  = PH_BODY;
                  num_ph_in = NUM_LEAD;
               end else begin
                  phase_in = PH_REJECT;
               end
            end
         end
         PH_BODY: begin
            // every star restarts the trailer; the last one wins
            if (b == afr_pkg::CH_STAR) begin
               crc_star_in    = crc_ff;
               len_star_in    = body_cnt_ff;
               commas_star_in = comma_cnt_ff;
               too_long_in    = body_cnt_ff > MAX_BODY_CNT;
               star_in        = 1'b1;
               nonspace_in    = 1'b0;
               hex_val_in     = 16'd0;
               hex_ph_in      = HEX_LEAD;
            end else if (star_ff) begin
               if (!afr_pkg::is_ws(b)) nonspace_in = 1'b1;
               unique case (hex_ph_ff)
                  HEX_LEAD: begin
                     if (!afr_pkg::is_ws(b)) begin
                        if (b == afr_pkg::CH_ZERO) begin
                           hex_val_in = 16'd0;
                           hex_ph_in  = HEX_ZERO;
                        end else if (hx[4]) begin
                           hex_val_in = {12'd0, hx[3:0]};
                           hex_ph_in  = HEX_DIGITS;
                        end else begin
                           hex_ph_in = HEX_DONE;
                        end
                     end
                  end
                  HEX_ZERO: begin
                     if (b == afr_pkg::CH_X_LO || b == afr_pkg::CH_X_UP) begin
                        hex_ph_in = HEX_DIGITS;
                     end else if (hx[4]) begin
                        hex_val_in = {12'd0, hx[3:0]};
                        hex_ph_in  = HEX_DIGITS;
                     end else begin
                        hex_ph_in = HEX_DONE;
                     end
                  end
                  HEX_DIGITS: begin
                     if (hx[4]) hex_val_in = {hex_val_ff[11:0], hx[3:0]};
                     else hex_ph_in = HEX_DONE;
                  end
                  HEX_DONE: begin
                     hex_ph_in = HEX_DONE;
                  end
                  default: hex_ph_in = HEX_DONE;
               endcase
            end

            if (b == afr_pkg::CH_COMMA && comma_cnt_ff < 3'd4) begin
               offs_in[comma_cnt_ff[1:0]] = body_cnt_ff[8] ? 8'hFF : body_cnt_ff[7:0];
               comma_cnt_in = comma_cnt_ff + 3'd1;
               if (comma_cnt_ff == 3'd0) num_ph_in = NUM_IDLE;
               if (comma_cnt_ff == 3'd3) begin
                  num_ph_in = NUM_LEAD;
                  seq_in    = 16'd0;
               end
            end else if (num_ph_ff != NUM_IDLE) begin
               // only the node field and the field after the fourth comma are numbers
               if (comma_cnt_ff != 3'd0 && comma_cnt_ff != 3'd4) begin
                  num_ph_in = NUM_IDLE;
               end else if (num_ph_ff == NUM_LEAD) begin
                  if (afr_pkg::is_ws(b)) begin
                     num_ph_in = NUM_LEAD;
                  end else if (b == afr_pkg::CH_PLUS) begin
                     num_ph_in = NUM_POS;
                  end else if (b == afr_pkg::CH_MINUS) begin
                     num_ph_in = NUM_NEG;
                  end else if (!dec) begin
                     num_ph_in = NUM_IDLE;
                  end else begin
                     num_ph_in = NUM_POS;
                     num_go    = 1'b1;
                  end
               end else if (!dec) begin
                  num_ph_in = NUM_IDLE;
               end else begin
                  num_go = 1'b1;
               end

               if (num_go) begin
                  if (comma_cnt_ff == 3'd0) begin
                     node_in = (num_ph_in == NUM_NEG) ? node_x10 - {4'd0, dval}
                                                      : node_x10 + {4'd0, dval};
                  end else begin
                     seq_in = (num_ph_in == NUM_NEG) ? seq_x10 - {12'd0, dval}
                                                     : seq_x10 + {12'd0, dval};
                  end
               end
            end

            crc_in = afr_pkg::crc_byte(crc_ff, b);
            if (!body_cnt_ff[8]) body_cnt_in = body_cnt_ff + 9'd1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (phase_in != PH_BODY) begin
         err = afr_pkg::ERR_NO_START;
      end else if (!star_in || len_star_in == 9'd0 || !nonspace_in) begin
         err = afr_pkg::ERR_STAR;
      end else if (too_long_in) begin
         err = afr_pkg::ERR_LONG;
      end else if (hex_val_in != crc_star_in) begin
         err = afr_pkg::ERR_CRC;
      end else if (commas_star_in < 3'd4) begin
         err = afr_pkg::ERR_COMMAS;
      end else begin
         err = afr_pkg::ERR_OK;
      end

      result            = '0;
      result.frame_ok   = (err == afr_pkg::ERR_OK);
      result.error_code = err;
      if (err == afr_pkg::ERR_OK) begin
         result.node_id      = node_in;
         result.seq_number   = seq_in;
         result.sep_offset_1 = offs_in[0];
         result.sep_offset_2 = offs_in[1];
         result.sep_offset_3 = offs_in[2];
         result.sep_offset_4 = offs_in[3];
      end
      if (err != afr_pkg::ERR_NO_START && err != afr_pkg::ERR_STAR) begin
         result.body_length  = len_star_in[8] ? 8'hFF : len_star_in[7:0];
         result.computed_crc = crc_star_in;
      end
   end

   // the line's last byte hands out its verdict and clears everything for the next line
   always_ff @(posedge clock) begin
      if (reset || (step && item.end_of_line)) begin
         phase_ff       <= PH_WAIT;
         crc_ff         <= afr_pkg::CRC_INIT;
         crc_star_ff    <= 16'd0;
         body_cnt_ff    <= 9'd0;
         len_star_ff    <= 9'd0;
         star_ff        <= 1'b0;
         nonspace_ff    <= 1'b0;
         hex_val_ff     <= 16'd0;
         hex_ph_ff      <= HEX_LEAD;
         comma_cnt_ff   <= 3'd0;
         commas_star_ff <= 3'd0;
         offs_ff        <= '0;
         node_ff        <= 8'd0;
         seq_ff         <= 16'd0;
         num_ph_ff      <= NUM_LEAD;
         too_long_ff    <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         crc_ff         <= crc_in;
         crc_star_ff    <= crc_star_in;
         body_cnt_ff    <= body_cnt_in;
         len_star_ff    <= len_star_in;
         star_ff        <= star_in;
         nonspace_ff    <= nonspace_in;
         hex_val_ff     <= hex_val_in;
         hex_ph_ff      <= hex_ph_in;
         comma_cnt_ff   <= comma_cnt_in;
         commas_star_ff <= commas_star_in;
         offs_ff        <= offs_in;
         node_ff        <= node_in;
         seq_ff         <= seq_in;
         num_ph_ff      <= num_ph_in;
         too_long_ff    <= too_long_in;
      end
   end

endmodule
